FILE: rtl/hav_pkg.sv
// Shared constants and helpers for the haversine distance pipeline.
// Holds the CORDIC arctangent table, fixed-point constants and angle reduction.
// No dependencies; every rtl module imports this package.
package hav_pkg;

    // Number of CORDIC micro-rotations in both the rotation and vectoring units.
    localparam int CORDIC_STEPS = 30;

    // Number of result bits produced by the integer square root pipeline.
    localparam int ISQRT_STEPS = 31;

    // CORDIC start vector length in Q30 (one over the CORDIC gain).
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Arctangent of 2^-i in phase units, where 2^32 is a full turn.
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // 360 degrees with 22 fraction bits, and twice that.
    localparam logic signed [33:0] FULL_TURN_S = 34'sd1509949440;
    localparam logic signed [33:0] TWO_TURNS_S = 34'sd3019898880;

    // floor(2^37 / 45): reciprocal used for the degree to phase scaling.
    localparam logic [31:0] DIV45_RECIP = 32'd3054198966;

    // floor(2^32 / 5): reciprocal used for the final unit scaling.
    localparam logic [31:0] DIV5_RECIP = 32'd858993459;

    // Pi in Q30.
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    // Sphere radius after reset.
    localparam logic [31:0] RADIUS_RESET = 32'd6371000;

    // Reduce a signed angle in degrees (Q22) into [0, 360) degrees.
    function automatic logic [30:0] reduce_turn(input logic signed [32:0] ang);
        logic signed [33:0] wide;
        logic signed [33:0] up1;
        logic signed [33:0] up2;
        logic signed [33:0] dn1;
        logic signed [33:0] res;
        wide = 34'(ang);
        up1  = wide + FULL_TURN_S;
        up2  = wide + TWO_TURNS_S;
        dn1  = wide - FULL_TURN_S;
        if (wide < 0) begin
            res = (up1 < 0) ? up2 : up1;
        end else if (wide >= FULL_TURN_S) begin
            res = dn1;
        end else begin
            res = wide;
        end
        return res[30:0];
    endfunction

endpackage

FILE: rtl/hav_cordic_rot.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit phase.
// One micro-rotation per register stage; depends on hav_pkg.
// Stages: fold stage, 30 rotation stages, sign and clamp stage.
module hav_cordic_rot (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_i,
    input  logic [31:0]         phase_i,
    output logic                valid_o,
    output logic signed [31:0]  cos_o,
    output logic signed [31:0]  sin_o
);
    import hav_pkg::*;

    logic signed [32:0] x_reg [0:CORDIC_STEPS];
    logic signed [32:0] y_reg [0:CORDIC_STEPS];
    logic signed [32:0] z_reg [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];
    logic               vld_reg [0:CORDIC_STEPS];
    logic               out_vld_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    logic [31:0]        tilt;
    logic               flip;
    logic [31:0]        pfold;
    logic signed [32:0] xf;
    logic signed [32:0] yf;

    // Clamp a CORDIC result to [-1, 1] in Q30; plus one needs 32 signed bits.
    function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
        logic signed [32:0] res;
        if (v > 33'sd1073741824) begin
            res = 33'sd1073741824;
        end else if (v < -33'sd1073741824) begin
            res = -33'sd1073741824;
        end else begin
            res = v;
        end
        return res[31:0];
    endfunction

    // Fold the phase into [-90, 90) degrees by a half turn when needed.
    assign tilt  = phase_i + 32'h4000_0000;
    assign flip  = tilt[31];
    assign pfold = {phase_i[31] ^ flip, phase_i[30:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= 33'($signed(pfold));
            flip_reg[0] <= flip;
        end
    end

    // One micro-rotation per stage, direction from the sign of the residual angle.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [32:0] atan;

        assign xs   = x_reg[i] >>> i;
        assign ys   = y_reg[i] >>> i;
        assign atan = $signed({1'b0, ATAN_TAB[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][32]) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan;
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // Undo the half-turn fold, then clamp both outputs.
    assign xf = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign yf = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= clamp_q30(xf);
            sin_reg <= clamp_q30(yf);
        end
    end

    assign valid_o = out_vld_reg;
    assign cos_o   = cos_reg;
    assign sin_o   = sin_reg;

endmodule

FILE: rtl/hav_isqrt.sv
// Pipelined floor integer square root of a Q60 value, giving a Q30 root.
// One result bit per register stage (31 stages); depends on hav_pkg.
module hav_isqrt (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         valid_i,
    input  logic [60:0]  radicand_i,
    output logic         valid_o,
    output logic [30:0]  root_o
);
    import hav_pkg::*;

    logic [61:0] v_reg [0:ISQRT_STEPS-1];
    logic [61:0] r_reg [0:ISQRT_STEPS-1];
    logic        vld_reg [0:ISQRT_STEPS-1];

    // Each stage tries one root bit, weighted 2^(60 - 2k) in the radicand.
    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
        localparam logic [61:0] BIT_W = 62'd1 << (60 - 2 * k);
        logic [61:0] cur_v;
        logic [61:0] cur_r;
        logic        cur_vld;
        logic [61:0] trial;

        if (k == 0) begin : g_first
            assign cur_v   = {1'b0, radicand_i};
            assign cur_r   = '0;
            assign cur_vld = valid_i;
        end else begin : g_next
            assign cur_v   = v_reg[k-1];
            assign cur_r   = r_reg[k-1];
            assign cur_vld = vld_reg[k-1];
        end

        assign trial = cur_r + BIT_W;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cur_v >= trial) begin
                    v_reg[k] <= cur_v - trial;
                    r_reg[k] <= (cur_r >> 1) + BIT_W;
                end else begin
                    v_reg[k] <= cur_v;
                    r_reg[k] <= cur_r >> 1;
                end
            end
        end
    end

    assign valid_o = vld_reg[ISQRT_STEPS-1];
    assign root_o  = r_reg[ISQRT_STEPS-1][30:0];

endmodule

FILE: rtl/hav_cordic_vec.sv
// Pipelined vectoring-mode CORDIC giving atan2(y, x) for x, y in [0, 1] Q30.
// One micro-rotation per stage plus a clamp stage; depends on hav_pkg.
// The angle comes out in phase units, clamped to [0, a quarter turn].
module hav_cordic_vec (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         valid_i,
    input  logic [30:0]  x_i,
    input  logic [30:0]  y_i,
    output logic         valid_o,
    output logic [30:0]  angle_o
);
    import hav_pkg::*;

    logic signed [33:0] x_reg [0:CORDIC_STEPS-1];
    logic signed [33:0] y_reg [0:CORDIC_STEPS-1];
    logic signed [32:0] z_reg [0:CORDIC_STEPS-1];
    logic               vld_reg [0:CORDIC_STEPS-1];
    logic               out_vld_reg;
    logic [30:0]        angle_reg;
    logic signed [32:0] z_last;

    // Rotate toward the x axis; a zero y leaves the stage unchanged.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [33:0] cur_x;
        logic signed [33:0] cur_y;
        logic signed [32:0] cur_z;
        logic               cur_vld;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [32:0] atan;

        if (i == 0) begin : g_first
            assign cur_x   = $signed({3'b000, x_i});
            assign cur_y   = $signed({3'b000, y_i});
            assign cur_z   = '0;
            assign cur_vld = valid_i;
        end else begin : g_next
            assign cur_x   = x_reg[i-1];
            assign cur_y   = y_reg[i-1];
            assign cur_z   = z_reg[i-1];
            assign cur_vld = vld_reg[i-1];
        end

        assign xs   = cur_x >>> i;
        assign ys   = cur_y >>> i;
        assign atan = $signed({1'b0, ATAN_TAB[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cur_y > 0) begin
                    x_reg[i] <= cur_x + ys;
                    y_reg[i] <= cur_y - xs;
                    z_reg[i] <= cur_z + atan;
                end else if (cur_y < 0) begin
                    x_reg[i] <= cur_x - ys;
                    y_reg[i] <= cur_y + xs;
                    z_reg[i] <= cur_z - atan;
                end else begin
                    x_reg[i] <= cur_x;
                    y_reg[i] <= cur_y;
                    z_reg[i] <= cur_z;
                end
            end
        end
    end

    assign z_last = z_reg[CORDIC_STEPS-1];

    // Clamp the accumulated angle to [0, a quarter turn].
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_last < 0) begin
                angle_reg <= '0;
            end else if (z_last > 33'sd1073741824) begin
                angle_reg <= 31'd1073741824;
            end else begin
                angle_reg <= z_last[30:0];
            end
        end
    end

    assign valid_o = out_vld_reg;
    assign angle_o = angle_reg;

endmodule

FILE: rtl/haversine_distance_top.sv
// Haversine great-circle distance, fully pipelined: one position pair per cycle,
// stalled only while the skid entry is full. The CORDIC and square root pipelines
// resolve one step per register stage. A two-entry output buffer keeps input
// flowing while one result waits. Reset (aresetn, synchronous, active low)
// empties the pipeline and sets the sphere radius to 6371000. Depends on hav_pkg
// and the hav_* submodules.
module haversine_distance_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [29:0]  s_first_latitude,
    input  logic signed [30:0]  s_first_longitude,
    input  logic signed [29:0]  s_second_latitude,
    input  logic signed [30:0]  s_second_longitude,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [38:0]         m_distance
);
    import hav_pkg::*;

    localparam logic signed [62:0] ONE_Q60_S = 63'sd1 <<< 60;
    localparam logic [60:0]        ONE_Q60_U = 61'd1 << 60;
    localparam logic [62:0]        C_ROUND   = 63'd524288;

    // Radius register.
    logic [31:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Global stage enable: the pipeline moves while the skid entry is free.
    logic        en;
    logic        skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Stage P1: angle differences and reduction into one turn.
    logic        p1_valid_reg;
    logic [30:0] ang_reg [0:3];
    logic signed [32:0] ang_in [0:3];

    assign ang_in[0] = 33'(s_first_latitude);
    assign ang_in[1] = 33'(s_second_latitude);
    assign ang_in[2] = 33'(s_second_latitude) - 33'(s_first_latitude);
    assign ang_in[3] = 33'(s_second_longitude) - 33'(s_first_longitude);

    // Stage P2 and P3: degrees to phase, by reciprocal multiply and correction.
    logic        p2_valid_reg;
    logic        p3_valid_reg;
    logic [31:0] q0_reg [0:3];
    logic [7:0]  nlo_reg [0:3];
    logic [31:0] phase_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_phase
        logic [37:0] n_val;
        logic [63:0] prod;
        logic [15:0] q45;
        logic [7:0]  rem;
        logic [1:0]  corr;

        // Full angles scale by 128/45, half differences by 64/45.
        if (k < 2) begin : g_full
            assign n_val = {ang_reg[k], 7'd0} + 38'd22;
        end else begin : g_half
            assign n_val = {1'b0, ang_reg[k], 6'd0} + 38'd22;
        end

        assign prod = 64'(n_val[37:6]) * 64'(DIV45_RECIP);
        assign q45  = 16'(q0_reg[k][7:0]) * 16'd45;
        assign rem  = nlo_reg[k] - q45[7:0];
        assign corr = 2'(rem >= 8'd45) + 2'(rem >= 8'd90) + 2'(rem >= 8'd135);

        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg[k]   <= reduce_turn(ang_in[k]);
                q0_reg[k]    <= prod[62:31];
                nlo_reg[k]   <= n_val[7:0];
                phase_reg[k] <= q0_reg[k] + 32'(corr);
            end
        end
    end

    // Cosines of both latitudes, sines of the half differences.
    logic               rot_valid;
    logic signed [31:0] cl1;
    logic signed [31:0] cl2;
    logic signed [31:0] s1;
    logic signed [31:0] s2;

    hav_cordic_rot u_rot_lat1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (p3_valid_reg),
        .phase_i (phase_reg[0]),
        .valid_o (rot_valid),
        .cos_o   (cl1),
        .sin_o   ()
    );

    hav_cordic_rot u_rot_lat2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (p3_valid_reg),
        .phase_i (phase_reg[1]),
        .valid_o (),
        .cos_o   (cl2),
        .sin_o   ()
    );

    hav_cordic_rot u_rot_dlat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (p3_valid_reg),
        .phase_i (phase_reg[2]),
        .valid_o (),
        .cos_o   (),
        .sin_o   (s1)
    );

    hav_cordic_rot u_rot_dlon (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (p3_valid_reg),
        .phase_i (phase_reg[3]),
        .valid_o (),
        .cos_o   (),
        .sin_o   (s2)
    );

    // Stages A1 to A4: a = s1^2 + ((cl1*cl2 >> 30) * s2 >> 30) * s2, clamped.
    logic               a1_valid_reg;
    logic               a2_valid_reg;
    logic               a3_valid_reg;
    logic               a4_valid_reg;
    logic signed [61:0] s1sq_a1_reg;
    logic signed [61:0] s1sq_a2_reg;
    logic signed [61:0] s1sq_a3_reg;
    logic signed [61:0] m12_reg;
    logic signed [31:0] s2_a1_reg;
    logic signed [31:0] s2_a2_reg;
    logic signed [61:0] pm_reg;
    logic signed [61:0] tm_reg;
    logic [60:0]        a_reg;
    logic [60:0]        b_reg;

    logic signed [61:0] m12_sh;
    logic signed [31:0] m30;
    logic signed [61:0] pm_sh;
    logic signed [31:0] m2;
    logic signed [62:0] a_sum;
    logic [60:0]        a_next;

    assign m12_sh = m12_reg >>> 30;
    assign m30    = m12_sh[31:0];
    assign pm_sh  = pm_reg >>> 30;
    assign m2     = pm_sh[31:0];
    assign a_sum  = 63'(s1sq_a3_reg) + 63'(tm_reg);

    always_comb begin
        if (a_sum < 0) begin
            a_next = '0;
        end else if (a_sum > ONE_Q60_S) begin
            a_next = ONE_Q60_U;
        end else begin
            a_next = a_sum[60:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
            a4_valid_reg <= 1'b0;
        end else if (en) begin
            a1_valid_reg <= rot_valid;
            a2_valid_reg <= a1_valid_reg;
            a3_valid_reg <= a2_valid_reg;
            a4_valid_reg <= a3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1sq_a1_reg <= 62'(s1) * 62'(s1);
            m12_reg     <= 62'(cl1) * 62'(cl2);
            s2_a1_reg   <= s2;
            pm_reg      <= 62'(m30) * 62'(s2_a1_reg);
            s2_a2_reg   <= s2_a1_reg;
            s1sq_a2_reg <= s1sq_a1_reg;
            tm_reg      <= 62'(m2) * 62'(s2_a2_reg);
            s1sq_a3_reg <= s1sq_a2_reg;
            a_reg       <= a_next;
            b_reg       <= ONE_Q60_U - a_next;
        end
    end

    // Square roots of a and 1 - a.
    logic        sqrt_valid;
    logic [30:0] root_a;
    logic [30:0] root_b;

    hav_isqrt u_sqrt_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_i    (a4_valid_reg),
        .radicand_i (a_reg),
        .valid_o    (sqrt_valid),
        .root_o     (root_a)
    );

    hav_isqrt u_sqrt_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_i    (a4_valid_reg),
        .radicand_i (b_reg),
        .valid_o    (),
        .root_o     (root_b)
    );

    // Half central angle as atan2(sqrt(a), sqrt(1 - a)).
    logic        vec_valid;
    logic [30:0] angle;

    hav_cordic_vec u_vec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (sqrt_valid),
        .x_i     (root_b),
        .y_i     (root_a),
        .valid_o (vec_valid),
        .angle_o (angle)
    );

    // Stages D1 to D6: scale to a central angle, multiply by radius, divide by 40960.
    logic        d1_valid_reg;
    logic        d2_valid_reg;
    logic        d3_valid_reg;
    logic        d4_valid_reg;
    logic        d5_valid_reg;
    logic        d6_valid_reg;
    logic [62:0] zpi_reg;
    logic [41:0] c_reg;
    logic [53:0] rch_reg;
    logic [51:0] rcl_reg;
    logic [40:0] u_reg;
    logic [38:0] q5_reg;
    logic [9:0]  ulo_reg;
    logic [38:0] dist_reg;

    logic [62:0] c_sum;
    logic [54:0] t_sum;
    logic [63:0] prod5;
    logic [12:0] q5x5;
    logic [9:0]  rem5;
    logic [17:0] rem_scaled;

    assign c_sum      = zpi_reg + C_ROUND;
    assign t_sum      = 55'(rch_reg) + 55'(rcl_reg[51:20]) + 55'd20480;
    assign prod5      = 64'(u_reg[40:9]) * 64'(DIV5_RECIP);
    assign q5x5       = 13'(q5_reg[9:0]) * 13'd5;
    assign rem5       = ulo_reg - q5x5[9:0];
    assign rem_scaled = 18'(rem5) * 18'd205;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            d4_valid_reg <= 1'b0;
            d5_valid_reg <= 1'b0;
            d6_valid_reg <= 1'b0;
        end else if (en) begin
            d1_valid_reg <= vec_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            d4_valid_reg <= d3_valid_reg;
            d5_valid_reg <= d4_valid_reg;
            d6_valid_reg <= d5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zpi_reg  <= 63'(angle) * 63'(PI_Q30);
            c_reg    <= c_sum[61:20];
            rch_reg  <= 54'(radius_reg) * 54'(c_reg[41:20]);
            rcl_reg  <= 52'(radius_reg) * 52'(c_reg[19:0]);
            u_reg    <= t_sum[53:13];
            q5_reg   <= prod5[61:23];
            ulo_reg  <= u_reg[9:0];
            dist_reg <= q5_reg + 39'(rem_scaled[17:10]);
        end
    end

    // Output register with one skid entry behind it.
    logic        deliver;
    logic        m_valid_reg;
    logic [38:0] m_dist_reg;
    logic [38:0] skid_dist_reg;
    logic        out_free;

    assign deliver  = en && d6_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg    <= skid_valid_reg || deliver;
            skid_valid_reg <= 1'b0;
        end else if (deliver) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_dist_reg <= skid_valid_reg ? skid_dist_reg : dist_reg;
        end else if (deliver) begin
            skid_dist_reg <= dist_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_dist_reg;

endmodule

FILE: test/haversine_distance_top_test.sv
// Self-checking testbench for haversine_distance_top: random and directed position pairs.
// Expected distances come from a fixed-point haversine predictor inside this file.
// Depends on hav_pkg and the rtl under test.
`timescale 1ns / 100ps

module haversine_distance_top_test;
    import hav_pkg::*;

    localparam int  HALF_PERIOD  = 1;
    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 150;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  MAX_REPORTS  = 10;
    localparam longint DEG360_Q22 = 64'sd1509949440;
    localparam longint LAT_MAX    = 64'sd377487360;
    localparam longint LON_MAX    = 64'sd754974720;
    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint ONE_Q60    = 64'sd1 << 60;

    typedef struct {
        logic signed [29:0] lat1;
        logic signed [30:0] lon1;
        logic signed [29:0] lat2;
        logic signed [30:0] lon2;
    } pos_pair_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [29:0] s_first_latitude;
    logic signed [30:0] s_first_longitude;
    logic signed [29:0] s_second_latitude;
    logic signed [30:0] s_second_longitude;
    logic               m_valid;
    logic               m_ready;
    logic [38:0]        m_distance;

    logic [31:0] radius_model;
    logic [38:0] pending_distances[$];
    int          mismatch_count;
    int          cycle_count;
    int          hold_request;

    haversine_distance_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_first_latitude  (s_first_latitude),
        .s_first_longitude (s_first_longitude),
        .s_second_latitude (s_second_latitude),
        .s_second_longitude(s_second_longitude),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_distance        (m_distance)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // ---------------- Predictor ----------------

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Degrees (Q22) to a 32-bit phase, scaled by mult/45 with rounding.
    function automatic logic [31:0] deg_to_phase(input longint deg, input longint mult);
        longint rem;
        longint scaled;
        rem = deg % DEG360_Q22;
        if (rem < 0) begin
            rem = rem + DEG360_Q22;
        end
        scaled = (rem * mult + 22) / 45;
        return scaled[31:0];
    endfunction

    // Rotation CORDIC giving cosine and sine in Q30.
    function automatic void phase_cos_sin(input logic [31:0] phase,
                                          output longint cos_q30, output longint sin_q30);
        logic [31:0]        p;
        logic [31:0]        probe;
        logic signed [31:0] ps;
        logic               flip;
        longint             x;
        longint             y;
        longint             z;
        longint             xn;
        p = phase;
        probe = p + 32'h40000000;
        flip = probe[31];
        if (flip) begin
            p = p + 32'h80000000;
        end
        ps = p;
        z = ps;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TAB[i]);
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TAB[i]);
            end
            x = xn;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q30 = clip(x, -ONE_Q30, ONE_Q30);
        sin_q30 = clip(y, -ONE_Q30, ONE_Q30);
    endfunction

    // Floor integer square root.
    function automatic longint floor_sqrt(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] b;
        v = value;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return longint'(root);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in phase units, clipped to a quarter turn.
    function automatic longint vector_angle(input longint x_in, input longint y_in);
        longint x;
        longint y;
        longint z;
        longint xn;
        x = x_in;
        y = y_in;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TAB[i]);
                x  = xn;
            end else if (y < 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TAB[i]);
                x  = xn;
            end
        end
        return clip(z, 0, ONE_Q30);
    endfunction

    function automatic logic [38:0] great_circle_distance(input pos_pair_t pp,
                                                          input logic [31:0] radius);
        longint      lat1;
        longint      lon1;
        longint      lat2;
        longint      lon2;
        longint      cos1;
        longint      cos2;
        longint      sin_dlat;
        longint      sin_dlon;
        longint      unused;
        longint      hav;
        longint      angle;
        longint      c_q40;
        logic [63:0] c_hi;
        logic [63:0] c_lo;
        logic [63:0] scaled;
        lat1 = pp.lat1;
        lon1 = pp.lon1;
        lat2 = pp.lat2;
        lon2 = pp.lon2;
        phase_cos_sin(deg_to_phase(lat1, 128), cos1, unused);
        phase_cos_sin(deg_to_phase(lat2, 128), cos2, unused);
        phase_cos_sin(deg_to_phase(lat2 - lat1, 64), unused, sin_dlat);
        phase_cos_sin(deg_to_phase(lon2 - lon1, 64), unused, sin_dlon);
        hav = sin_dlat * sin_dlat + ((((cos1 * cos2) >>> 30) * sin_dlon) >>> 30) * sin_dlon;
        hav = clip(hav, 0, ONE_Q60);
        angle = vector_angle(floor_sqrt(64'(ONE_Q60 - hav)), floor_sqrt(64'(hav)));
        c_q40 = (angle * 64'sd3373259426 + (64'sd1 << 19)) >>> 20;
        c_hi = 64'(c_q40) >> 20;
        c_lo = 64'(c_q40) & 64'hFFFFF;
        scaled = 64'(radius) * c_hi + ((64'(radius) * c_lo) >> 20);
        scaled = (scaled + 20480) / 40960;
        return scaled[38:0];
    endfunction

    // ---------------- Drivers ----------------

    // Idle length: mostly none or short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one word; idles for the given cycles first, keeps valid high otherwise.
    task automatic send_pair(input pos_pair_t pp, input int idle);
        if (idle > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (idle - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid            <= 1'b1;
        s_first_latitude   <= pp.lat1;
        s_first_longitude  <= pp.lon1;
        s_second_latitude  <= pp.lat2;
        s_second_longitude <= pp.lon2;
        do @(posedge aclk); while (!s_ready);
        pending_distances.push_back(great_circle_distance(pp, radius_model));
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Wait until every expected distance has come back.
    task automatic wait_drained();
        while (pending_distances.size() != 0) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [31:0] radius);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= radius;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        radius_model = radius;
    endtask

    function automatic pos_pair_t make_pair(input longint lat1, input longint lon1,
                                            input longint lat2, input longint lon2);
        pos_pair_t pp;
        pp.lat1 = lat1[29:0];
        pp.lon1 = lon1[30:0];
        pp.lat2 = lat2[29:0];
        pp.lon2 = lon2[30:0];
        return pp;
    endfunction

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    // Random pair: mostly valid coordinates, some raw bit patterns, some near twins.
    function automatic pos_pair_t random_pair();
        pos_pair_t pp;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            pp = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                           rand_span(LAT_MAX), rand_span(LON_MAX));
        end else if (roll < 85) begin
            pp.lat1 = 30'($urandom());
            pp.lon1 = 31'($urandom());
            pp.lat2 = 30'($urandom());
            pp.lon2 = 31'($urandom());
        end else begin
            pp = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX), 0, 0);
            pp.lat2 = pp.lat1 + 30'($urandom_range(0, 2000)) - 30'sd1000;
            pp.lon2 = pp.lon1 + 31'($urandom_range(0, 2000)) - 31'sd1000;
        end
        return pp;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_pair(random_pair(), gap_length());
        end
        stop_sending();
    endtask

    // ---------------- Tests ----------------

    // Edge coordinates: poles, date line, antipodes, identical points, wrapped values.
    task automatic test_directed();
        pos_pair_t cases[$];
        cases.push_back(make_pair(0, 0, 0, 0));
        cases.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
        cases.push_back(make_pair(0, 0, 0, LON_MAX));
        cases.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
        cases.push_back(make_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
        cases.push_back(make_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX));
        cases.push_back(make_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2,
                                  LON_MAX / 3 - LON_MAX));
        cases.push_back(make_pair(1, 1, 0, 0));
        cases.push_back(make_pair(123456789, -98765432, 123456789, -98765432));
        cases.push_back(make_pair(-(64'sd1 << 29), -(64'sd1 << 30),
                                  (64'sd1 << 29) - 1, (64'sd1 << 30) - 1));
        cases.push_back(make_pair((64'sd1 << 29) - 1, (64'sd1 << 30) - 1,
                                  -(64'sd1 << 29), -(64'sd1 << 30)));
        cases.push_back(make_pair(-1, -1, -1, -1));
        cases.push_back(make_pair(0, 0, 1, 0));
        cases.push_back(make_pair(LAT_MAX, 0, LAT_MAX, LON_MAX / 2));
        cases.push_back(make_pair(0, LON_MAX / 2, 0, -LON_MAX / 2));
        foreach (cases[i]) begin
            send_pair(cases[i], (i % 3 == 0) ? 0 : gap_length());
        end
        stop_sending();
    endtask

    task automatic test_reset_radius();
        send_random(350);
    endtask

    task automatic test_radius_extremes();
        write_radius(32'd1);
        send_random(150);
        write_radius(32'hFFFFFFFF);
        send_random(250);
        write_radius(32'd0);
        test_directed();
        send_random(40);
    endtask

    task automatic test_random_radius();
        for (int k = 0; k < 4; k++) begin
            write_radius($urandom());
            send_random(60);
        end
    endtask

    // Receiver holds off long enough for the pipeline and buffer to fill.
    task automatic test_backpressure();
        write_radius(RADIUS_RESET);
        hold_request = 400;
        for (int n = 0; n < 250; n++) begin
            send_pair(random_pair(), 0);
        end
        stop_sending();
    endtask

    // ---------------- Receiver and checker ----------------

    // Result-side ready: random stalls, or one long hold when requested.
    initial begin
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_length();
            end
        end
    end

    // Compare each accepted distance word with the oldest expectation.
    always @(posedge aclk) begin
        logic [38:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected distance word %0d", m_distance);
            end else begin
                want = pending_distances.pop_front();
                if (m_distance !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("distance mismatch: expected %0d, got %0d", want, m_distance);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- Sequence ----------------

    initial begin
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        s_valid            = 1'b0;
        s_first_latitude   = '0;
        s_first_longitude  = '0;
        s_second_latitude  = '0;
        s_second_longitude = '0;
        radius_model       = RADIUS_RESET;
        mismatch_count     = 0;
        cycle_count        = 0;
        hold_request       = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_reset_radius();
        test_radius_extremes();
        test_random_radius();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_distances.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/hav_pkg.sv
rtl/hav_cordic_rot.sv
rtl/hav_isqrt.sv
rtl/hav_cordic_vec.sv
rtl/haversine_distance_top.sv
test/haversine_distance_top_test.sv
